[sv/lmf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package lmf_pkg;
   localparam int DEF_INPUTS = 8;
   localparam int DEF_OUTPUTS = 4;
   localparam int DEF_HIDDEN_LAYERS = 2;
   localparam int DEF_NEURONS = 16;
   localparam int POS_W = 9;
   localparam int VAL_W = 16;
   localparam int OPOS_W = 2;

   typedef enum logic {
      CMD_WEIGHT = 1'b0,
      CMD_FEATURE = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_MAC,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   // classified word handed from front to back
   typedef struct packed {
      logic is_weight;
      logic is_feature;
      logic is_last;
      logic [POS_W-1:0] position;
      logic [VAL_W-1:0] value;
   } job_type;

   // Q16.16 sum to Q8.8, round half up, saturate
   function automatic logic [VAL_W-1:0] narrow(input logic signed [47:0] acc);
      logic signed [47:0] r;
      logic signed [39:0] q;
      begin
         r = acc + 48'sd128;
         q = r[47:8];
         if (q > 40'sd32767) narrow = 16'h7fff;
         else if (q < -40'sd32768) narrow = 16'h8000;
         else narrow = q[15:0];
      end
   endfunction
endpackage
`default_nettype wire

[sv/linear_mlp_forward.sv]
// One shared MAC works through every layer once the last feature word is taken.
// Weight and feature words pass through a two-word queue.
// Results of one vector are given one at a time; no word leaves the queue during a pass.
// Synchronous active-high reset clears control; weight and neuron stores stay undefined.
`timescale 1ns / 1ps
`default_nettype none
module linear_mlp_forward #(
   parameter int INPUTS = lmf_pkg::DEF_INPUTS,
   parameter int OUTPUTS = lmf_pkg::DEF_OUTPUTS,
   parameter int HIDDEN_LAYERS = lmf_pkg::DEF_HIDDEN_LAYERS,
   parameter int NEURONS = lmf_pkg::DEF_NEURONS
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic req_cmd,
   input  wire logic [lmf_pkg::POS_W-1:0] req_position,
   input  wire logic signed [lmf_pkg::VAL_W-1:0] req_value,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic [lmf_pkg::OPOS_W-1:0] rsp_out_position,
   output logic signed [lmf_pkg::VAL_W-1:0] rsp_out_value,
   output logic rsp_out_last
);
   localparam int DEPTH = INPUTS * NEURONS + NEURONS * OUTPUTS
                          + (HIDDEN_LAYERS - 1) * NEURONS * NEURONS;
   logic q_valid, q_ready;
   lmf_pkg::job_type q_job;

   lmf_front #(.INPUTS(INPUTS), .DEPTH(DEPTH)) u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_cmd(req_cmd), .req_position(req_position), .req_value(req_value),
      .q_valid(q_valid), .q_ready(q_ready), .q_job(q_job));

   lmf_back #(.INPUTS(INPUTS), .OUTPUTS(OUTPUTS), .HIDDEN_LAYERS(HIDDEN_LAYERS),
              .NEURONS(NEURONS), .DEPTH(DEPTH)) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_ready(q_ready),
      .q_job(q_job), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_out_position(rsp_out_position), .rsp_out_value(rsp_out_value),
      .rsp_out_last(rsp_out_last));
endmodule
`default_nettype wire

[sv/lmf_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module lmf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 448
) (
   input  wire logic clock,
   input  wire logic wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

[sv/lmf_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module lmf_front #(
   parameter int INPUTS = lmf_pkg::DEF_INPUTS,
   parameter int DEPTH = 448
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic req_cmd,
   input  wire logic [lmf_pkg::POS_W-1:0] req_position,
   input  wire logic [lmf_pkg::VAL_W-1:0] req_value,
   output logic q_valid,
   input  wire logic q_ready,
   output lmf_pkg::job_type q_job
);
   // two-entry queue
   lmf_pkg::job_type mem_ff [2];
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   lmf_pkg::job_type job;
   logic push, pop;

   always_comb begin
      job.position = req_position;
      job.value = req_value;
      job.is_weight = (req_cmd == lmf_pkg::CMD_WEIGHT)
                      && (32'(req_position) < DEPTH);
      job.is_feature = (req_cmd == lmf_pkg::CMD_FEATURE)
                       && (32'(req_position) < INPUTS);
      job.is_last = job.is_feature && (32'(req_position) == INPUTS - 1);
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign push = req_valid && req_ready;
   assign q_valid = (cnt_ff != 2'd0);
   assign pop = q_valid && q_ready;
   assign q_job = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= job;
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("queue count overflow");
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd0 |-> !pop) else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !push) else $error("push into full queue");
endmodule
`default_nettype wire

[sv/lmf_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module lmf_back #(
   parameter int INPUTS = lmf_pkg::DEF_INPUTS,
   parameter int OUTPUTS = lmf_pkg::DEF_OUTPUTS,
   parameter int HIDDEN_LAYERS = lmf_pkg::DEF_HIDDEN_LAYERS,
   parameter int NEURONS = lmf_pkg::DEF_NEURONS,
   parameter int DEPTH = 448
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic q_valid,
   output logic q_ready,
   input  wire lmf_pkg::job_type q_job,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic [lmf_pkg::OPOS_W-1:0] rsp_out_position,
   output logic [lmf_pkg::VAL_W-1:0] rsp_out_value,
   output logic rsp_out_last
);
   localparam int AW = $clog2(DEPTH);
   localparam int OW_BASE = INPUTS * NEURONS;
   localparam int LW_BASE = OW_BASE + NEURONS * OUTPUTS;
   localparam int MAXN = (INPUTS > NEURONS) ? INPUTS : NEURONS;
   localparam int IW = (MAXN > 1) ? $clog2(MAXN) : 1;
   localparam int NW = (NEURONS > 1) ? $clog2(NEURONS) : 1;
   localparam int JW = $clog2(((NEURONS > OUTPUTS) ? NEURONS : OUTPUTS) + 1);
   localparam int LW = $clog2(HIDDEN_LAYERS + 1);
   localparam int FW = (INPUTS > 1) ? $clog2(INPUTS) : 1;
   localparam int VW = lmf_pkg::VAL_W;

   // phase: 0 first hidden, 1 further hidden, 2 outputs
   localparam logic [1:0] PH_IN = 2'd0;
   localparam logic [1:0] PH_HID = 2'd1;
   localparam logic [1:0] PH_OUT = 2'd2;

   lmf_pkg::state_type state_ff, state_in;
   logic [1:0] ph_ff, ph_in;
   logic [LW-1:0] layer_ff, layer_in;
   logic [JW-1:0] j_ff, j_in;
   logic [IW-1:0] i_ff, i_in;
   logic p1_ff, p2_ff;
   logic [IW-1:0] i1_ff;
   logic signed [VW-1:0] a2_ff;
   logic signed [VW-1:0] b2_ff;
   logic signed [31:0] prod_ff;
   logic prod_v_ff;
   logic signed [47:0] acc_ff;
   logic [VW-1:0] feat_ff [INPUTS];
   logic [VW-1:0] nprev_ff [NEURONS];
   logic [VW-1:0] ncurr_ff [NEURONS];
   logic [VW-1:0] res_ff;
   logic [JW-1:0] out_idx_ff;
   logic rsp_valid_ff;

   logic wr_en;
   logic [AW-1:0] rd_addr;
   logic [VW-1:0] rd_data;
   logic [31:0] addr_calc;
   logic n_last, j_last;
   logic [IW-1:0] n_count;
   logic [JW-1:0] j_count;
   logic [VW-1:0] narrowed;

   assign wr_en = q_valid && q_ready && q_job.is_weight;

   lmf_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_store (
      .clock(clock), .wr_en(wr_en), .wr_addr(q_job.position[AW-1:0]),
      .wr_data(q_job.value), .rd_addr(rd_addr), .rd_data(rd_data));

   always_comb begin
      n_count = (ph_ff == PH_IN) ? IW'(INPUTS - 1) : IW'(NEURONS - 1);
      j_count = (ph_ff == PH_OUT) ? JW'(OUTPUTS - 1) : JW'(NEURONS - 1);
      n_last = (i_ff == n_count);
      j_last = (j_ff == j_count);
      unique case (ph_ff)
         PH_IN: addr_calc = 32'(i_ff) * NEURONS + 32'(j_ff);
         PH_HID: addr_calc = LW_BASE + (32'(layer_ff) * NEURONS + 32'(i_ff)) * NEURONS
                             + 32'(j_ff);
         default: addr_calc = OW_BASE + 32'(i_ff) * OUTPUTS + 32'(j_ff);
      endcase
      rd_addr = addr_calc[AW-1:0];
      narrowed = lmf_pkg::narrow(acc_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lmf_pkg::ST_IDLE:
            if (q_valid && q_job.is_last) state_in = lmf_pkg::ST_FILL;
         lmf_pkg::ST_FILL: state_in = lmf_pkg::ST_MAC;
         lmf_pkg::ST_MAC: if (n_last) state_in = lmf_pkg::ST_DRAIN;
         lmf_pkg::ST_DRAIN:
            if (p1_ff || p2_ff || prod_v_ff) state_in = lmf_pkg::ST_DRAIN;
            else if (ph_ff == PH_OUT) state_in = lmf_pkg::ST_EMIT;
            else state_in = lmf_pkg::ST_FILL;
         lmf_pkg::ST_EMIT:
            if (rsp_ready) state_in = j_last && (ph_ff == PH_OUT)
                                      && (out_idx_ff == JW'(OUTPUTS - 1))
                                      ? lmf_pkg::ST_IDLE : lmf_pkg::ST_FILL;
         default: state_in = lmf_pkg::ST_IDLE;
      endcase
   end

   // outputs and counters
   always_comb begin
      q_ready = (state_ff == lmf_pkg::ST_IDLE);
      ph_in = ph_ff;
      layer_in = layer_ff;
      j_in = j_ff;
      i_in = i_ff;
      unique case (state_ff)
         lmf_pkg::ST_IDLE:
            if (q_valid && q_job.is_last) begin
               ph_in = PH_IN;
               layer_in = '0;
               j_in = '0;
               i_in = '0;
            end
         lmf_pkg::ST_FILL: i_in = '0;
         lmf_pkg::ST_MAC: if (!n_last) i_in = i_ff + 1'b1;
         lmf_pkg::ST_DRAIN:
            if (!(p1_ff || p2_ff || prod_v_ff) && ph_ff != PH_OUT) begin
               if (!j_last) j_in = j_ff + 1'b1;
               else begin
                  j_in = '0;
                  // another layer-to-layer stage follows, else the outputs
                  if ((ph_ff == PH_IN) ? (HIDDEN_LAYERS > 1)
                                       : (32'(layer_ff) + 2 < HIDDEN_LAYERS)) begin
                     ph_in = PH_HID;
                     layer_in = (ph_ff == PH_IN) ? '0 : layer_ff + 1'b1;
                     if (ph_ff == PH_IN) layer_in = '0;
                  end else ph_in = PH_OUT;
               end
            end
         lmf_pkg::ST_EMIT: if (rsp_ready && !j_last) j_in = j_ff + 1'b1;
         default: ;
      endcase
   end

   logic [VW-1:0] opnd;
   always_comb begin
      if (ph_ff == PH_IN) opnd = feat_ff[i1_ff[FW-1:0]];
      else opnd = nprev_ff[i1_ff[NW-1:0]];
   end

   logic hid_done;
   assign hid_done = (state_ff == lmf_pkg::ST_DRAIN) && !(p1_ff || p2_ff || prod_v_ff)
                     && ph_ff != PH_OUT && j_last;

   always_ff @(posedge clock) begin
      if (q_valid && q_ready && q_job.is_feature)
         feat_ff[q_job.position[FW-1:0]] <= q_job.value;
      i1_ff <= i_ff;
      a2_ff <= opnd;
      // weight delayed to line up with its operand
      b2_ff <= rd_data;
      prod_ff <= $signed(a2_ff) * $signed(b2_ff);
      if (state_ff == lmf_pkg::ST_FILL) acc_ff <= '0;
      else if (prod_v_ff) acc_ff <= acc_ff + 48'(prod_ff);
      if (state_ff == lmf_pkg::ST_DRAIN && !(p1_ff || p2_ff || prod_v_ff)) begin
         if (ph_ff == PH_OUT) begin
            res_ff <= narrowed;
            out_idx_ff <= j_ff;
         end else ncurr_ff[j_ff[NW-1:0]] <= narrowed;
      end
      if (hid_done) begin
         for (int n = 0; n < NEURONS; n++)
            nprev_ff[n] <= (n == 32'(j_ff)) ? narrowed : ncurr_ff[n];
      end
      if (reset) begin
         state_ff <= lmf_pkg::ST_IDLE;
         ph_ff <= PH_IN;
         layer_ff <= '0;
         j_ff <= '0;
         i_ff <= '0;
         p1_ff <= 1'b0;
         p2_ff <= 1'b0;
         prod_v_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ph_ff <= ph_in;
         layer_ff <= layer_in;
         j_ff <= j_in;
         i_ff <= i_in;
         p1_ff <= (state_ff == lmf_pkg::ST_MAC);
         p2_ff <= p1_ff;
         prod_v_ff <= p2_ff;
         if (state_in == lmf_pkg::ST_EMIT && state_ff != lmf_pkg::ST_EMIT)
            rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_position = lmf_pkg::OPOS_W'(out_idx_ff);
   assign rsp_out_value = res_ff;
   assign rsp_out_last = (out_idx_ff == JW'(OUTPUTS - 1));

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == lmf_pkg::ST_EMIT) else $error("result outside emit");
   assert property (@(posedge clock) disable iff (reset)
      q_ready |-> !p1_ff && !p2_ff && !prod_v_ff) else $error("mac busy while idle");
   assert property (@(posedge clock) disable iff (reset)
      prod_v_ff |=> state_ff != lmf_pkg::ST_EMIT) else $error("emit before drain");
endmodule
`default_nettype wire
